[rtl/vtu_pkg.sv]
// Package for the vertex transform unit: widths, modes, CORDIC constants.
// Used by vtu_cordic and vertex_transform_unit_top.
`default_nettype none
package vtu_pkg;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int DATA_W  = 32;
  localparam int ANG_W   = 36;
  localparam int RED_W   = 56;
  localparam int CX_W    = 34;

  localparam logic [1:0] MODE_TRANSLATE = 2'd0;
  localparam logic [1:0] MODE_ROTATE    = 2'd1;
  localparam logic [1:0] MODE_SCALE     = 2'd2;
  localparam logic [1:0] MODE_PASS      = 2'd3;

  localparam logic [1:0] REG_OP_MODE = 2'd0;
  localparam logic [1:0] REG_PARAM_X = 2'd1;
  localparam logic [1:0] REG_PARAM_Y = 2'd2;
  localparam logic [1:0] REG_PARAM_Z = 2'd3;

  localparam logic signed [CX_W-1:0]  K_Q30       = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    begin
      case (i)
        5'd0: v = 36'sd843314856;   5'd1: v = 36'sd497837829;
        5'd2: v = 36'sd263043836;   5'd3: v = 36'sd133525158;
        5'd4: v = 36'sd67021686;    5'd5: v = 36'sd33543515;
        5'd6: v = 36'sd16775850;    5'd7: v = 36'sd8388437;
        5'd8: v = 36'sd4194282;     5'd9: v = 36'sd2097149;
        5'd10: v = 36'sd1048575;    5'd11: v = 36'sd524287;
        5'd12: v = 36'sd262143;     5'd13: v = 36'sd131071;
        5'd14: v = 36'sd65535;      5'd15: v = 36'sd32767;
        5'd16: v = 36'sd16383;      5'd17: v = 36'sd8191;
        5'd18: v = 36'sd4095;       5'd19: v = 36'sd2047;
        5'd20: v = 36'sd1023;       5'd21: v = 36'sd511;
        5'd22: v = 36'sd255;        5'd23: v = 36'sd127;
        5'd24: v = 36'sd63;         5'd25: v = 36'sd31;
        5'd26: v = 36'sd15;         5'd27: v = 36'sd7;
        5'd28: v = 36'sd3;          5'd29: v = 36'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [CX_W-1:0] sin_v;
    logic signed [CX_W-1:0] cos_v;
  } cordic_rsp_t;
endpackage
`default_nettype wire

[rtl/vtu_cordic.sv]
// Iterative CORDIC sine/cosine in Q30, one micro-rotation per cycle.
// Angle reduced modulo 2*pi by shifted compare and subtract, one step per cycle.
// Depends on vtu_pkg; driven by vertex_transform_unit_top.
`default_nettype none
module vtu_cordic
  import vtu_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);
  localparam int STEPS = (CORDIC_STEPS > 30) ? 30 : CORDIC_STEPS;
  localparam int MOD_TOP = 28 - FRAC_BITS;

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001, C_MOD = 5'b00010, C_RED = 5'b00100, C_ITER = 5'b01000,
    C_DONE = 5'b10000
  } cst_t;

  cst_t st_r, st_nxt;
  logic signed [ANG_W-1:0] r_r, r_nxt;
  logic signed [RED_W-1:0] m_r, m_nxt;
  logic signed [CX_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic                    neg_r, neg_nxt;
  logic [4:0]              i_r, i_nxt;
  logic signed [RED_W-1:0] a_wide, t_sh;
  logic signed [ANG_W-1:0] m_base, a_mod, a_red;
  logic signed [CX_W-1:0]  xs, ys;

  always_comb begin
    a_wide = RED_W'(req.angle) <<< (30 - FRAC_BITS);
    t_sh   = RED_W'(TWO_PI_Q30) <<< i_r;
    m_base = ANG_W'(m_r);
    if (m_base > PI_Q30)       a_mod = m_base - TWO_PI_Q30;
    else if (m_base < -PI_Q30) a_mod = m_base + TWO_PI_Q30;
    else                       a_mod = m_base;
    a_red = a_mod;
    if (a_mod > HALF_PI_Q30)       a_red = PI_Q30 - a_mod;
    else if (a_mod < -HALF_PI_Q30) a_red = -PI_Q30 - a_mod;
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
  end

  always_comb begin
    st_nxt = st_r; r_nxt = r_r; m_nxt = m_r; x_nxt = x_r; y_nxt = y_r;
    neg_nxt = neg_r; i_nxt = i_r;
    case (st_r)
      C_IDLE: if (req.start) begin
        m_nxt = a_wide;
        i_nxt = 5'(MOD_TOP);
        st_nxt = C_MOD;
      end
      C_MOD: begin
        if (m_r >= 0 && m_r >= t_sh)    m_nxt = m_r - t_sh;
        else if (m_r < 0 && m_r <= -t_sh) m_nxt = m_r + t_sh;
        i_nxt = i_r - 5'd1;
        if (i_r == 5'd0) st_nxt = C_RED;
      end
      C_RED: begin
        r_nxt = a_red;
        neg_nxt = (a_mod > HALF_PI_Q30) || (a_mod < -HALF_PI_Q30);
        x_nxt = K_Q30; y_nxt = '0; i_nxt = '0;
        st_nxt = C_ITER;
      end
      C_ITER: begin
        if (r_r >= 0) begin
          x_nxt = x_r - ys; y_nxt = y_r + xs; r_nxt = r_r - atan_q30(i_r);
        end else begin
          x_nxt = x_r + ys; y_nxt = y_r - xs; r_nxt = r_r + atan_q30(i_r);
        end
        i_nxt = i_r + 5'd1;
        if (i_r == 5'(STEPS - 1)) st_nxt = C_DONE;
      end
      C_DONE: begin
        if (neg_r) x_nxt = -x_r;
        st_nxt = C_IDLE;
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= C_IDLE;
    else        st_r <= st_nxt;
    r_r <= r_nxt; m_r <= m_nxt; x_r <= x_nxt; y_r <= y_nxt; neg_r <= neg_nxt;
    i_r <= i_nxt;
  end

  // done is seen in the cycle after C_DONE, when x holds the final cosine
  logic done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else        done_r <= (st_r == C_DONE);
  end

  assign rsp.done  = done_r;
  assign rsp.sin_v = y_r;
  assign rsp.cos_v = x_r;
endmodule
`default_nettype wire

[rtl/vertex_transform_unit_top.sv]
// Vertex transform unit: translate, scale, Euler rotate or pass-through of Q16.16 points.
// A config write clears the cached matrix, so the next rotate input rebuilds it first.
// One item in flight; the next input is accepted once the result has left and
// no config write is pending.
// Synchronous active-low reset clears mode, params, matrix and the matrix valid flag.
`default_nettype none
module vertex_transform_unit_top
  import vtu_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,   // in_x, in_y, in_z
  input  wire logic         s_axis_tuser,   // point_kind
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata,   // out_x, out_y, out_z
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [65:0] ONE_F = 66'sd1 <<< FRAC_BITS;

  typedef enum logic [7:0] {
    S_IDLE = 8'h01, S_CORD = 8'h02, S_CWAIT = 8'h04, S_MBLD = 8'h08,
    S_MFIN = 8'h10, S_MUL = 8'h20, S_FIN = 8'h40, S_OUT = 8'h80
  } st_t;

  st_t st_r, st_nxt;
  logic [1:0]  mode_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic        mvalid_r;
  logic signed [31:0] mat_r [9];
  logic signed [31:0] v_r [3];
  logic        kind_r;
  logic signed [CX_W-1:0] sc_r [6]; // sx cx sy cy sz cz
  logic signed [CX_W-1:0] t_r [2];  // sx*sy, cx*sy
  logic signed [65:0] acc_r;
  logic signed [31:0] res_r [3];
  logic [4:0]  k_r, k_nxt;
  logic [1:0]  ax_r;

  cordic_req_t creq;
  cordic_rsp_t crsp;

  vtu_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp)
  );

  assign cfg_ready     = (st_r == S_IDLE);
  assign s_axis_tready = (st_r == S_IDLE) && !cfg_valid;
  assign m_axis_tvalid = (st_r == S_OUT);
  assign m_axis_tdata  = {res_r[2], res_r[1], res_r[0]};

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647)       return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  function automatic logic signed [CX_W-1:0] rnd30(input logic signed [65:0] p);
    logic signed [65:0] q;
    q = (p + (66'sd1 <<< 29)) >>> 30;
    return q[CX_W-1:0];
  endfunction

  // shared multiplier: operands chosen by state, step counter and axis
  logic signed [CX_W-1:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [65:0] prod_r;
  always_comb begin
    ma = '0; mb = '0;
    case (st_r)
      S_MBLD: begin
        case (k_r)
          5'd0: begin ma = sc_r[0]; mb = sc_r[2]; end
          5'd1: begin ma = sc_r[1]; mb = sc_r[2]; end
          5'd2: begin ma = sc_r[3]; mb = sc_r[5]; end
          5'd3: begin ma = sc_r[3]; mb = sc_r[4]; end
          5'd4: begin ma = t_r[0];  mb = sc_r[5]; end
          5'd5: begin ma = sc_r[1]; mb = sc_r[4]; end
          5'd6: begin ma = t_r[0];  mb = sc_r[4]; end
          5'd7: begin ma = sc_r[1]; mb = sc_r[5]; end
          5'd8: begin ma = sc_r[0]; mb = sc_r[3]; end
          5'd9: begin ma = t_r[1];  mb = sc_r[5]; end
          5'd10: begin ma = sc_r[0]; mb = sc_r[4]; end
          5'd11: begin ma = t_r[1]; mb = sc_r[4]; end
          5'd12: begin ma = sc_r[0]; mb = sc_r[5]; end
          5'd13: begin ma = sc_r[1]; mb = sc_r[3]; end
          default: ;
        endcase
      end
      S_MUL: begin
        if (k_r[1:0] != 2'd3) begin
          ma = CX_W'(mat_r[{ax_r, 1'b0} + ax_r + 4'(k_r[1:0])]);
          mb = CX_W'(v_r[k_r[1:0]]);
        end
      end
      default: begin
        ma = CX_W'(v_r[ax_r]);
        mb = (ax_r == 2'd0) ? CX_W'(px_r) : (ax_r == 2'd1) ? CX_W'(py_r) : CX_W'(pz_r);
      end
    endcase
    prod = 66'(ma) * 66'(mb);
  end

  // matrix build pipeline: step k multiplies, k-1 result is consumed
  logic signed [65:0] e_r; // accumulating entry in Q30
  logic signed [65:0] e_rnd;
  logic signed [31:0] e_q;
  always_comb begin
    e_rnd = (e_r + (66'sd1 <<< (SH - 1))) >>> SH;
    if (e_rnd > ONE_F)       e_q = 32'(ONE_F);
    else if (e_rnd < -ONE_F) e_q = 32'(-ONE_F);
    else                     e_q = e_rnd[31:0];
  end

  logic [1:0] cidx_r;
  logic [3:0] eidx_r;
  logic       ewr_r;

  always_comb begin
    st_nxt = st_r; k_nxt = k_r;
    creq.start = 1'b0;
    creq.angle = (cidx_r == 2'd0) ? px_r : (cidx_r == 2'd1) ? py_r : pz_r;
    case (st_r)
      S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        if (mode_r == MODE_ROTATE && !mvalid_r) st_nxt = S_CORD;
        else if (mode_r == MODE_ROTATE) begin st_nxt = S_MUL; k_nxt = '0; end
        else st_nxt = S_FIN;
        k_nxt = '0;
      end
      S_CORD: begin creq.start = 1'b1; st_nxt = S_CWAIT; end
      S_CWAIT: if (crsp.done) begin
        if (cidx_r == 2'd2) begin st_nxt = S_MBLD; k_nxt = '0; end
        else st_nxt = S_CORD;
      end
      S_MBLD: begin
        k_nxt = k_r + 5'd1;
        if (k_r == 5'd14) st_nxt = S_MFIN;
      end
      S_MFIN: begin st_nxt = S_MUL; k_nxt = '0; end
      S_MUL: begin
        k_nxt = k_r + 5'd1;
        if (k_r[1:0] == 2'd3) begin
          k_nxt = '0;
          if (ax_r == 2'd2) st_nxt = S_OUT;
        end
      end
      S_FIN: begin
        k_nxt = k_r + 5'd1;
        if (k_r == 5'd3) st_nxt = S_OUT;
      end
      S_OUT: if (m_axis_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Q30 product of previous step, rounded
  logic signed [CX_W-1:0] pr30;
  assign pr30 = rnd30(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; mode_r <= MODE_TRANSLATE;
      px_r <= '0; py_r <= '0; pz_r <= '0; mvalid_r <= 1'b0;
      for (int i = 0; i < 9; i++) mat_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        mvalid_r <= 1'b0;
        case (cfg_index)
          REG_OP_MODE: mode_r <= cfg_data[1:0];
          REG_PARAM_X: px_r <= cfg_data;
          REG_PARAM_Y: py_r <= cfg_data;
          REG_PARAM_Z: pz_r <= cfg_data;
          default: ;
        endcase
      end
      if (st_r == S_MFIN) mvalid_r <= 1'b1;
      if (ewr_r) mat_r[eidx_r] <= e_q;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    prod_r <= prod;
    ewr_r <= 1'b0;
    case (st_r)
      S_IDLE: begin
        v_r[0] <= s_axis_tdata[31:0];
        v_r[1] <= s_axis_tdata[63:32];
        v_r[2] <= s_axis_tdata[95:64];
        kind_r <= s_axis_tuser;
        cidx_r <= '0; ax_r <= '0; acc_r <= '0;
      end
      S_CWAIT: if (crsp.done) begin
        sc_r[{cidx_r, 1'b0}]        <= crsp.sin_v;
        sc_r[{cidx_r, 1'b0} + 3'd1] <= crsp.cos_v;
        cidx_r <= cidx_r + 2'd1;
      end
      S_MBLD: begin
        // product of step k-1 is in prod_r; flag an entry once it is complete
        case (k_r)
          5'd1: t_r[0] <= pr30;
          5'd2: t_r[1] <= pr30;
          5'd3: begin e_r <= 66'(pr30); ewr_r <= 1'b1; eidx_r <= 4'd0; end
          5'd4: begin e_r <= -66'(pr30); ewr_r <= 1'b1; eidx_r <= 4'd1; end
          5'd5: e_r <= 66'(pr30);
          5'd6: begin e_r <= e_r + 66'(pr30); ewr_r <= 1'b1; eidx_r <= 4'd3; end
          5'd7: e_r <= -66'(pr30);
          5'd8: begin e_r <= e_r + 66'(pr30); ewr_r <= 1'b1; eidx_r <= 4'd4; end
          5'd9: begin e_r <= -66'(pr30); ewr_r <= 1'b1; eidx_r <= 4'd5; end
          5'd10: e_r <= -66'(pr30);
          5'd11: begin e_r <= e_r + 66'(pr30); ewr_r <= 1'b1; eidx_r <= 4'd6; end
          5'd12: e_r <= 66'(pr30);
          5'd13: begin e_r <= e_r + 66'(pr30); ewr_r <= 1'b1; eidx_r <= 4'd7; end
          5'd14: begin e_r <= 66'(pr30); ewr_r <= 1'b1; eidx_r <= 4'd8; end
          default: ;
        endcase
      end
      S_MFIN: begin
        e_r <= 66'(sc_r[2]); ewr_r <= 1'b1; eidx_r <= 4'd2;
      end
      S_MUL: begin
        if (k_r[1:0] == 2'd1 || k_r[1:0] == 2'd2) acc_r <= acc_r + prod_r;
        if (k_r[1:0] == 2'd3) begin
          res_r[ax_r] <= sat32((acc_r + prod_r + (66'sd1 <<< (FRAC_BITS - 1)))
                               >>> FRAC_BITS);
          acc_r <= '0;
          ax_r <= ax_r + 2'd1;
        end
      end
      S_FIN: begin
        if (k_r != 5'd0) begin
          if (mode_r == MODE_TRANSLATE && !kind_r)
            res_r[ax_r - 2'd1] <= sat32(66'(v_r[ax_r - 2'd1]) + 66'(
              (ax_r == 2'd1) ? px_r : (ax_r == 2'd2) ? py_r : pz_r));
          else if (mode_r == MODE_SCALE && !kind_r)
            res_r[ax_r - 2'd1] <= sat32((prod_r + (66'sd1 <<< (FRAC_BITS - 1)))
                                        >>> FRAC_BITS);
          else
            res_r[ax_r - 2'd1] <= v_r[ax_r - 2'd1];
        end
        if (k_r != 5'd3) ax_r <= ax_r + 2'd1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[dv/tb.sv]
// Testbench for vertex_transform_unit_top: translate, rotate, scale and pass of Q16.16 points.
// Predicts each result in place (CORDIC sin/cos, cached matrix) and checks the stream.
// Depends on vtu_pkg and the top-level RTL only.
`timescale 1ns / 100ps
module tb;
  import vtu_pkg::*;

  localparam int FB = 16;
  localparam int STEPS = 16;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  logic clk = 0;
  logic rst_n = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  vertex_transform_unit_top u_top (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  logic [1:0] mode_q;
  logic signed [31:0] par_q [3];
  longint mat_q [9];
  bit mat_ok;
  point_t expected_pts [$];
  int errors = 0;
  bit hold_off = 0;
  bit stall_mode = 1;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_tab(int i);
    longint t [30] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1};
    return t[i];
  endfunction

  task automatic sincos(input logic signed [31:0] ang, output longint s, output longint c);
    longint r, x, y, nx;
    bit negc;
    r = longint'(ang) * (longint'(1) <<< (30 - FB));
    x = 652032874;
    y = 0;
    negc = 0;
    r = r % 64'sd6746518852;
    if (r > 64'sd3373259426) r -= 64'sd6746518852;
    if (r < -64'sd3373259426) r += 64'sd6746518852;
    if (r > 64'sd1686629713) begin
      r = 64'sd3373259426 - r; negc = 1;
    end else if (r < -64'sd1686629713) begin
      r = -64'sd3373259426 - r; negc = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (r >= 0) begin
        nx = x - fshr(y, i); y = y + fshr(x, i); r -= atan_tab(i);
      end else begin
        nx = x + fshr(y, i); y = y - fshr(x, i); r += atan_tab(i);
      end
      x = nx;
    end
    s = y;
    c = negc ? -x : x;
  endtask

  function automatic longint m30(longint a, longint b);
    return rshr(a * b, 30);
  endfunction

  task automatic build_rotation();
    longint sx, cx, sy, cy, sz, cz, v;
    longint m [9];
    sincos(par_q[0], sx, cx);
    sincos(par_q[1], sy, cy);
    sincos(par_q[2], sz, cz);
    m[0] = m30(cy, cz);
    m[1] = -m30(cy, sz);
    m[2] = sy;
    m[3] = m30(m30(sx, sy), cz) + m30(cx, sz);
    m[4] = -m30(m30(sx, sy), sz) + m30(cx, cz);
    m[5] = -m30(sx, cy);
    m[6] = -m30(m30(cx, sy), cz) + m30(sx, sz);
    m[7] = m30(m30(cx, sy), sz) + m30(sx, cz);
    m[8] = m30(cx, cy);
    for (int i = 0; i < 9; i++) begin
      v = rshr(m[i], 30 - FB);
      if (v > (longint'(1) <<< FB)) v = longint'(1) <<< FB;
      if (v < -(longint'(1) <<< FB)) v = -(longint'(1) <<< FB);
      mat_q[i] = v;
    end
    mat_ok = 1;
  endtask

  task automatic transform_point(input bit normal, input point_t p, output point_t r);
    longint v [3], o [3], acc;
    v[0] = longint'(signed'(p.x));
    v[1] = longint'(signed'(p.y));
    v[2] = longint'(signed'(p.z));
    for (int k = 0; k < 3; k++) o[k] = v[k];
    if (mode_q == MODE_ROTATE) begin
      if (!mat_ok) build_rotation();
      for (int k = 0; k < 3; k++) begin
        acc = mat_q[3*k] * v[0] + mat_q[3*k+1] * v[1] + mat_q[3*k+2] * v[2];
        o[k] = sat32(rshr(acc, FB));
      end
    end else if (mode_q == MODE_TRANSLATE && !normal) begin
      for (int k = 0; k < 3; k++) o[k] = sat32(v[k] + longint'(par_q[k]));
    end else if (mode_q == MODE_SCALE && !normal) begin
      for (int k = 0; k < 3; k++) o[k] = sat32(rshr(v[k] * longint'(par_q[k]), FB));
    end
    r.x = o[0][31:0];
    r.y = o[1][31:0];
    r.z = o[2][31:0];
  endtask

  // Point packing: x in the lowest bits.
  function automatic logic [95:0] pack_pt(point_t p);
    return {p.z, p.y, p.x};
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_OP_MODE: mode_q = val[1:0];
      REG_PARAM_X: par_q[0] = val;
      REG_PARAM_Y: par_q[1] = val;
      default: par_q[2] = val;
    endcase
    mat_ok = 0;
  endtask

  task automatic drain();
    int n = 0;
    while (expected_pts.size() != 0 && n < 200000) begin
      @(posedge clk); n++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] pz);
    drain();
    write_reg(REG_PARAM_X, px);
    write_reg(REG_PARAM_Y, py);
    write_reg(REG_PARAM_Z, pz);
    write_reg(REG_OP_MODE, mode);
    cfg_valid <= 0;
  endtask

  // Hold tvalid across back-to-back items; drop only on a gap.
  task automatic send_point(input bit normal, input point_t p);
    point_t r;
    s_axis_tvalid <= 1;
    s_axis_tuser <= normal;
    s_axis_tdata <= pack_pt(p);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    transform_point(normal, p, r);
    expected_pts.insert(expected_pts.size(), r);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
      3: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.x = rand_word(); p.y = rand_word(); p.z = rand_word();
    return p;
  endfunction

  task automatic random_burst_run(input int count);
    int burst;
    int sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_point($urandom_range(0, 1), rand_point());
        sent++;
      end
      idle_sender($urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
    end
    idle_sender(1);
  endtask

  task automatic test_directed();
    point_t maxp = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    point_t minp = '{32'h80000000, 32'h80000000, 32'h80000000};
    point_t unit = '{32'h00010000, 32'hfffe8000, 32'h00030000};
    configure(MODE_TRANSLATE, 32'h7fffffff, 32'h80000000, 32'h00010000);
    send_point(0, maxp); send_point(0, minp); send_point(1, maxp); send_point(0, unit);
    idle_sender(1);
    configure(MODE_SCALE, 32'h7fffffff, 32'h80000000, 32'hffff8000);
    send_point(0, maxp); send_point(0, minp); send_point(1, unit); send_point(0, unit);
    idle_sender(1);
    // Angles: zero, beyond pi, extremes
    configure(MODE_ROTATE, 32'h0, 32'h0, 32'h0);
    send_point(0, unit); send_point(1, maxp);
    idle_sender(1);
    configure(MODE_ROTATE, 32'h0001921f, 32'h00040000, 32'hfffb0000);
    send_point(0, unit); send_point(1, minp); send_point(0, maxp);
    idle_sender(1);
    configure(MODE_ROTATE, 32'h7fffffff, 32'h80000000, 32'h00032440);
    send_point(0, unit); send_point(1, unit); send_point(0, minp);
    idle_sender(1);
    configure(MODE_PASS, 32'h1234, 32'h5678, 32'h9abc);
    send_point(0, unit); send_point(1, maxp);
    idle_sender(1);
  endtask

  task automatic test_random_modes();
    logic [1:0] m;
    for (int ph = 0; ph < 24; ph++) begin
      m = 2'(ph % 3);
      if (m == MODE_ROTATE)
        configure(m, $urandom_range(0, 3) == 0 ? rand_word() : 32'($urandom_range(0, 800000)) - 400000,
                  32'($urandom_range(0, 800000)) - 400000, rand_word());
      else if (m == MODE_SCALE)
        configure(m, 32'($urandom_range(0, 1 << 20)) - (1 << 19), rand_word(),
                  32'($urandom_range(0, 1 << 18)));
      else
        configure(m, rand_word(), rand_word(), rand_word());
      random_burst_run(64);
    end
    configure(MODE_PASS, rand_word(), rand_word(), rand_word());
    random_burst_run(40);
  endtask

  task automatic test_backpressure();
    configure(MODE_SCALE, 32'h00020000, 32'hffff0000, 32'h00008000);
    hold_off = 1;
    for (int i = 0; i < 30; i++) send_point($urandom_range(0, 1), rand_point());
    idle_sender(1);
  endtask

  // Receiver stall pattern; long hold-off when requested.
  always @(posedge clk) begin
    if (hold_off) begin
      m_axis_tready <= 0;
    end else if (stall_mode) begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_axis_tready <= 1;
    end
  end

  initial begin
    int cnt;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        cnt = 0;
        while (cnt < 300) begin
          @(posedge clk); cnt++;
        end
        hold_off = 0;
      end
    end
  end

  always @(posedge clk) begin
    point_t got, exp_p;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      got.x = m_axis_tdata[31:0];
      got.y = m_axis_tdata[63:32];
      got.z = m_axis_tdata[95:64];
      if (expected_pts.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        exp_p = expected_pts.pop_front();
        if (got.x !== exp_p.x) begin
          $error("out_x expected %h actual %h", exp_p.x, got.x); errors++;
        end
        if (got.y !== exp_p.y) begin
          $error("out_y expected %h actual %h", exp_p.y, got.y); errors++;
        end
        if (got.z !== exp_p.z) begin
          $error("out_z expected %h actual %h", exp_p.z, got.z); errors++;
        end
      end
    end
  end

  initial begin
    mode_q = MODE_TRANSLATE;
    par_q = '{0, 0, 0};
    mat_ok = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_modes();
    stall_mode = 0;
    configure(MODE_ROTATE, 32'h00010000, 32'hffff0000, 32'h00020000);
    random_burst_run(60);
    drain();
    if (errors == 0 && expected_pts.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

[vertex_transform_unit_top.f]
rtl/vtu_pkg.sv
rtl/vtu_cordic.sv
rtl/vertex_transform_unit_top.sv
dv/tb.sv
